// File: rtl/oscws_pkg.sv
// Shared types, constants and functions of the oscillator waveform shaper.
// Holds the quarter-wave sine table, built at elaboration, and the sample rounding.
// Depends on nothing; every other rtl file imports it.
`timescale 1ns / 1ps
`default_nettype none

package oscws_pkg;

   localparam int PHASE_BITS       = 24;
   localparam int SINE_TABLE_DEPTH = 256;
   localparam int SAMPLE_BITS      = 16;
   localparam int OPCODE_BITS      = 3;

   localparam int FRAC_BITS   = SAMPLE_BITS - 1;
   localparam int QTR_BITS    = PHASE_BITS - 2;
   localparam int QTR_W       = QTR_BITS + 1;
   localparam int IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
   localparam int IDX_W       = IDX_BITS + 1;
   localparam int INTERP_BITS = QTR_BITS - IDX_BITS;
   localparam int V_BITS      = PHASE_BITS + 3;
   localparam int ROUND_SHIFT = PHASE_BITS - FRAC_BITS;
   localparam int ROM_BITS    = SAMPLE_BITS;
   localparam int PROD_BITS   = 2 * PHASE_BITS;

   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   localparam logic [PHASE_BITS-1:0] HALF_Q = PHASE_BITS'(64'd1 << (PHASE_BITS - 1));
   localparam logic [PHASE_BITS-1:0] QTR_Q  = PHASE_BITS'(64'd1 << (PHASE_BITS - 2));
   localparam logic [PHASE_BITS-1:0] THREE_QTR_Q = HALF_Q + QTR_Q;
   localparam logic [QTR_W-1:0]      QTR_R  = QTR_W'(64'd1 << QTR_BITS);

   localparam logic signed [V_BITS-1:0] ONE_V = V_BITS'(64'd1 << PHASE_BITS);
   localparam logic signed [V_BITS-1:0] ROUND_HALF = V_BITS'(64'd1 << (ROUND_SHIFT - 1));
   localparam logic signed [V_BITS-1:0] CLAMP_HI = V_BITS'((64'd1 << FRAC_BITS) - 64'd1);
   localparam logic signed [V_BITS-1:0] CLAMP_LO = V_BITS'(-(longint'(1) << FRAC_BITS));

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_SINE     = 3'd0,
      OP_SQUARE   = 3'd1,
      OP_TRIANGLE = 3'd2,
      OP_SAW      = 3'd3,
      OP_MOOGSAW  = 3'd4,
      OP_MOOG     = 3'd5,
      OP_EXP      = 3'd6,
      OP_EXP2     = 3'd7
   } opcode_type;

   // Front stage result: sine addressing, multiplier operands, linear shapes.
   typedef struct packed {
      opcode_type                op;
      logic                      neg;
      logic [IDX_W-1:0]          idx;
      logic [INTERP_BITS-1:0]    frac;
      logic [PHASE_BITS-1:0]     mul_a;
      logic [PHASE_BITS-1:0]     mul_b;
      logic                      quad_x4;
      logic signed [V_BITS-1:0]  lin_v;
   } front_type;

   // Eval stage result: table pair, square product, rounded linear sample.
   typedef struct packed {
      opcode_type                    op;
      logic                          neg;
      logic [ROM_BITS-1:0]           lo;
      logic [ROM_BITS-1:0]           diff;
      logic [INTERP_BITS-1:0]        frac;
      logic [PHASE_BITS-1:0]         sq;
      logic                          quad_x4;
      logic signed [SAMPLE_BITS-1:0] lin_sample;
   } eval_type;

   typedef logic [ROM_BITS-1:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   // Quarter-wave sine, Q30 Taylor series, rounded to FRAC_BITS fraction bits.
   // Each odd-power term is the previous one times a^2 over (n-1)*n.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type      rom;
      longint unsigned   a;
      longint unsigned   a2;
      longint unsigned   t;
      longint            s;
      int                i;
      for (i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         a  = (PI_HALF_Q30 * longint'(i) + (64'd1 << (IDX_BITS - 1))) >> IDX_BITS;
         a2 = (a * a) >> 30;
         t  = a;
         s  = longint'(a);
         t  = ((t * a2) >> 30) / 64'd6;
         s  = s - longint'(t);
         t  = ((t * a2) >> 30) / 64'd20;
         s  = s + longint'(t);
         t  = ((t * a2) >> 30) / 64'd42;
         s  = s - longint'(t);
         t  = ((t * a2) >> 30) / 64'd72;
         s  = s + longint'(t);
         t  = ((t * a2) >> 30) / 64'd110;
         s  = s - longint'(t);
         t  = ((t * a2) >> 30) / 64'd156;
         s  = s + longint'(t);
         t  = ((t * a2) >> 30) / 64'd210;
         s  = s - longint'(t);
         if (s < 0) begin
            s = 0;
         end
         rom[i] = ROM_BITS'((unsigned'(s) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(
      input logic signed [V_BITS-1:0] v
   );
      logic signed [V_BITS-1:0] c;
      if (v > CLAMP_HI) begin
         c = CLAMP_HI;
      end else if (v < CLAMP_LO) begin
         c = CLAMP_LO;
      end else begin
         c = v;
      end
      return c[SAMPLE_BITS-1:0];
   endfunction

   // Round to nearest, ties upward, from PHASE_BITS to FRAC_BITS fraction bits.
   function automatic logic signed [SAMPLE_BITS-1:0] to_sample(
      input logic signed [V_BITS-1:0] v
   );
      logic signed [V_BITS-1:0] t;
      t = (v + ROUND_HALF) >>> ROUND_SHIFT;
      return clamp_sample(t);
   endfunction

endpackage

`default_nettype wire

// File: rtl/oscws_front.sv
// Front stage: folds the phase for sine addressing, picks the square-law operands
// and evaluates the piecewise linear shapes. Depends on oscws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oscws_front (
   input  logic                               clock,
   input  logic                               load,
   input  logic [oscws_pkg::PHASE_BITS-1:0]   phase,
   input  logic [oscws_pkg::OPCODE_BITS-1:0]  opcode,
   output oscws_pkg::front_type               front_ff
);
   import oscws_pkg::*;

   front_type                front_in;
   opcode_type               op;
   logic [1:0]               quad;
   logic [QTR_W-1:0]         r;
   logic [PHASE_BITS-1:0]    y;
   logic                     above_half;
   logic signed [V_BITS-1:0] xv;

   always_comb begin
      op         = opcode_type'(opcode);
      quad       = phase[PHASE_BITS-1 -: 2];
      r          = {1'b0, phase[QTR_BITS-1:0]};
      // mirror the second and fourth quarters
      if (quad[0]) begin
         r = QTR_R - r;
      end
      y          = PHASE_BITS'(0) - phase;
      above_half = phase > HALF_Q;
      xv         = signed'(V_BITS'(phase));

      front_in.op   = op;
      front_in.neg  = quad[1];
      front_in.idx  = r[QTR_BITS -: IDX_W];
      front_in.frac = r[INTERP_BITS-1:0];

      unique case (op)
         OP_SQUARE:   front_in.lin_v = (phase >= HALF_Q) ? -ONE_V : ONE_V;
         OP_TRIANGLE: begin
            if (phase < QTR_Q) begin
               front_in.lin_v = xv <<< 2;
            end else if (phase < THREE_QTR_Q) begin
               front_in.lin_v = (ONE_V <<< 1) - (xv <<< 2);
            end else begin
               front_in.lin_v = (xv <<< 2) - (ONE_V <<< 2);
            end
         end
         OP_SAW:      front_in.lin_v = (xv <<< 1) - ONE_V;
         OP_MOOGSAW:  front_in.lin_v = (phase < HALF_Q) ? ((xv <<< 2) - ONE_V)
                                                         : (ONE_V - (xv <<< 1));
         default:     front_in.lin_v = '0;
      endcase

      front_in.mul_a   = phase;
      front_in.mul_b   = phase;
      front_in.quad_x4 = 1'b0;
      unique case (op)
         OP_MOOG: begin
            if (above_half) begin
               front_in.mul_a   = y;
               front_in.mul_b   = y;
               front_in.quad_x4 = 1'b1;
            end
         end
         OP_EXP: begin
            if (above_half) begin
               front_in.mul_a = y;
               front_in.mul_b = y;
            end
         end
         OP_EXP2: begin
            if (above_half) begin
               front_in.mul_a = y;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         front_ff <= front_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/oscws_eval.sv
// Eval stage: reads the sine table pair, forms the square-law product and
// rounds the linear shapes to a sample. Depends on oscws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oscws_eval (
   input  logic                  clock,
   input  logic                  load,
   input  oscws_pkg::front_type  front,
   output oscws_pkg::eval_type   eval_ff
);
   import oscws_pkg::*;

   eval_type               eval_in;
   logic [ROM_BITS-1:0]    lo;
   logic [ROM_BITS-1:0]    hi;
   logic [PROD_BITS-1:0]   prod;

   always_comb begin
      lo = SINE_ROM[front.idx];
      if (front.idx < IDX_W'(SINE_TABLE_DEPTH)) begin
         hi = SINE_ROM[front.idx + 1'b1];
      end else begin
         hi = lo;
      end
      prod = PROD_BITS'(front.mul_a) * PROD_BITS'(front.mul_b);

      eval_in.op         = front.op;
      eval_in.neg        = front.neg;
      eval_in.lo         = lo;
      eval_in.diff       = (hi < lo) ? '0 : (hi - lo);
      eval_in.frac       = front.frac;
      eval_in.sq         = prod[PROD_BITS-1 -: PHASE_BITS];
      eval_in.quad_x4    = front.quad_x4;
      eval_in.lin_sample = to_sample(front.lin_v);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         eval_ff <= eval_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/oscws_finish.sv
// Finish stage: interpolates the sine, scales and rounds the square-law shapes
// and registers the selected sample. Depends on oscws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oscws_finish (
   input  logic                                  clock,
   input  logic                                  load,
   input  oscws_pkg::eval_type                   eval,
   output logic signed [oscws_pkg::SAMPLE_BITS-1:0] sample_ff
);
   import oscws_pkg::*;

   localparam int INTERP_W = ROM_BITS + INTERP_BITS;

   logic [INTERP_W-1:0]           interp;
   logic [ROM_BITS:0]             mag;
   logic signed [V_BITS-1:0]      sine_v;
   logic signed [V_BITS-1:0]      quad_v;
   logic signed [SAMPLE_BITS-1:0] sine_sample;
   logic signed [SAMPLE_BITS-1:0] quad_sample;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   always_comb begin
      interp = INTERP_W'(eval.diff) * INTERP_W'(eval.frac);
      mag    = {1'b0, eval.lo} + (ROM_BITS + 1)'(interp >> INTERP_BITS);
      sine_v = signed'(V_BITS'(mag));
      if (eval.neg) begin
         sine_v = -sine_v;
      end
      sine_sample = clamp_sample(sine_v);

      if (eval.quad_x4) begin
         quad_v = (signed'(V_BITS'(eval.sq)) <<< 2) - ONE_V;
      end else begin
         quad_v = (signed'(V_BITS'(eval.sq)) <<< 3) - ONE_V;
      end
      quad_sample = to_sample(quad_v);

      unique case (eval.op)
         OP_SINE:                 sample_in = sine_sample;
         OP_MOOG, OP_EXP, OP_EXP2: sample_in = quad_sample;
         default:                 sample_in = eval.lin_sample;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= sample_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/oscillator_waveform_shaper.sv
// Top level of the oscillator waveform shaper: input register, three compute
// stages and the valid/stall chain. Depends on oscws_pkg and the oscws_* stages.
//
//   channel | ports                                  | direction
//   req     | req_valid, req_stall, req_phase, req_opcode | in (req_stall out)
//   rsp     | rsp_valid, rsp_stall, rsp_sample       | out (rsp_stall in)
//
// One transaction enters per cycle while req_stall is low; its sample is offered
// once it has passed the input register (loaded at acceptance), then front, eval with
// table and multiplier, and the finish/output register.
// Each stage moves when it is empty or the next stage moves, so bubbles collapse
// and a stalled rsp holds every occupied stage without loss or repeat.
// Synchronous reset clears only the valid bits; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module oscillator_waveform_shaper (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [oscws_pkg::PHASE_BITS-1:0]         req_phase,
   input  logic [oscws_pkg::OPCODE_BITS-1:0]        req_opcode,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [oscws_pkg::SAMPLE_BITS-1:0] rsp_sample
);
   import oscws_pkg::*;

   logic                    s1_valid_ff;
   logic                    s2_valid_ff;
   logic                    s3_valid_ff;
   logic                    out_valid_ff;
   logic                    s1_valid_in;
   logic                    s2_valid_in;
   logic                    s3_valid_in;
   logic                    out_valid_in;
   logic [PHASE_BITS-1:0]   phase_ff;
   logic [OPCODE_BITS-1:0]  opcode_ff;
   logic                    rdy1;
   logic                    rdy2;
   logic                    rdy3;
   logic                    rdy4;
   front_type               front;
   eval_type                eval;

   always_comb begin
      rdy4 = !out_valid_ff || !rsp_stall;
      rdy3 = !s3_valid_ff || rdy4;
      rdy2 = !s2_valid_ff || rdy3;
      rdy1 = !s1_valid_ff || rdy2;

      s1_valid_in  = rdy1 ? req_valid   : s1_valid_ff;
      s2_valid_in  = rdy2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in  = rdy3 ? s2_valid_ff : s3_valid_ff;
      out_valid_in = rdy4 ? s3_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         phase_ff  <= req_phase;
         opcode_ff <= req_opcode;
      end
   end

   oscws_front u_front (
      .clock    (clock),
      .load     (rdy2),
      .phase    (phase_ff),
      .opcode   (opcode_ff),
      .front_ff (front)
   );

   oscws_eval u_eval (
      .clock   (clock),
      .load    (rdy3),
      .front   (front),
      .eval_ff (eval)
   );

   oscws_finish u_finish (
      .clock     (clock),
      .load      (rdy4),
      .eval      (eval),
      .sample_ff (rsp_sample)
   );

   assign req_stall = !rdy1;
   assign rsp_valid = out_valid_ff;

   // a free output side never backs up into the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("req stalled while rsp side is free");

   // an accepted transaction lands in the input register
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted transaction lost at input register");

   // a blocked middle stage keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !rdy4) |=> s3_valid_ff)
      else $error("eval stage dropped a stalled transaction");

   // output stage fed while stalled would overwrite a pending sample
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sample)))
      else $error("pending sample changed under stall");

endmodule

`default_nettype wire

// File: tb/sv/tb_oscillator_waveform_shaper.sv
// Self-checking testbench for oscillator_waveform_shaper: drives phase/shape
// transactions with random idle and stall bursts and predicts every sample.
// Depends on oscws_pkg and the rtl of oscillator_waveform_shaper.
`timescale 1ns / 1ps

module tb_oscillator_waveform_shaper;
   import oscws_pkg::*;

   localparam int RANDOM_ITEMS  = 1930;
   localparam int BLOCK_ITEMS   = 100;
   localparam int QUIET_ITEMS   = 300;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int REPORT_LIMIT  = 10;

   class shaper_scoreboard;
      longint unsigned quarter_sine [0:SINE_TABLE_DEPTH];
      logic signed [SAMPLE_BITS-1:0] expected_samples [$];
      int noted;
      int checked;
      int mismatches;

      // Build the quarter-wave table from a Q30 odd-power series.
      function new();
         longint unsigned angle;
         longint unsigned angle_sq;
         longint unsigned term;
         longint acc;
         int i;
         int k;
         noted = 0;
         checked = 0;
         mismatches = 0;
         for (i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            angle = (PI_HALF_Q30 * longint'(i) + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
            angle_sq = (angle * angle) >> 30;
            term = angle;
            acc = longint'(angle);
            for (k = 3; k <= 15; k += 2) begin
               term = ((term * angle_sq) >> 30) / longint'((k - 1) * k);
               if ((((k - 1) / 2) % 2) == 1) begin
                  acc -= longint'(term);
               end else begin
                  acc += longint'(term);
               end
            end
            if (acc < 0) begin
               acc = 0;
            end
            quarter_sine[i] = (longint'(acc) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
         end
      endfunction

      function logic signed [SAMPLE_BITS-1:0] clamp_code(longint v);
         if (v > (longint'(1) << FRAC_BITS) - 1) begin
            return SAMPLE_BITS'((longint'(1) << FRAC_BITS) - 1);
         end else if (v < -(longint'(1) << FRAC_BITS)) begin
            return SAMPLE_BITS'(-(longint'(1) << FRAC_BITS));
         end
         return SAMPLE_BITS'(v);
      endfunction

      // Round half up from phase fraction bits to sample fraction bits.
      function logic signed [SAMPLE_BITS-1:0] settle_sample(longint v);
         return clamp_code((v + (longint'(1) << (PHASE_BITS - FRAC_BITS - 1)))
                           >>> (PHASE_BITS - FRAC_BITS));
      endfunction

      function longint square_q(longint unsigned a, longint unsigned b);
         return longint'((a * b) >> PHASE_BITS);
      endfunction

      function logic signed [SAMPLE_BITS-1:0] sine_sample(logic [PHASE_BITS-1:0] x);
         longint unsigned quarter;
         longint unsigned r;
         longint unsigned pos;
         longint unsigned idx;
         longint unsigned frac;
         longint unsigned lo;
         longint unsigned hi;
         longint unsigned mag;
         logic [1:0] quad;
         quarter = 64'd1 << (PHASE_BITS - 2);
         quad = x[PHASE_BITS-1 -: 2];
         r = longint'(x) & (quarter - 1);
         // Mirror the phase in the second and fourth quadrants.
         if (quad[0]) begin
            r = quarter - r;
         end
         pos = r * SINE_TABLE_DEPTH;
         idx = pos >> (PHASE_BITS - 2);
         frac = pos & (quarter - 1);
         lo = quarter_sine[idx];
         hi = (idx < SINE_TABLE_DEPTH) ? quarter_sine[idx + 1] : lo;
         if (hi < lo) begin
            hi = lo;
         end
         mag = lo + (((hi - lo) * frac) >> (PHASE_BITS - 2));
         return quad[1] ? clamp_code(-longint'(mag)) : clamp_code(longint'(mag));
      endfunction

      function logic signed [SAMPLE_BITS-1:0] predict_sample(logic [PHASE_BITS-1:0] x,
                                                             opcode_type op);
         longint one;
         longint half;
         longint qtr;
         longint xs;
         longint y;
         longint v;
         one = longint'(1) << PHASE_BITS;
         half = one / 2;
         qtr = one / 4;
         xs = x;
         v = 0;
         case (op)
            OP_SINE: begin
               return sine_sample(x);
            end
            OP_SQUARE: begin
               v = (xs >= half) ? -one : one;
            end
            OP_TRIANGLE: begin
               if (xs < qtr) v = 4 * xs;
               else if (xs < 3 * qtr) v = 2 * one - 4 * xs;
               else v = 4 * xs - 4 * one;
            end
            OP_SAW: begin
               v = 2 * xs - one;
            end
            OP_MOOGSAW: begin
               v = (xs < half) ? 4 * xs - one : one - 2 * xs;
            end
            OP_MOOG: begin
               if (xs > half) begin
                  y = one - xs;
                  v = 4 * square_q(y, y) - one;
               end else begin
                  v = 8 * square_q(xs, xs) - one;
               end
            end
            OP_EXP: begin
               y = (xs > half) ? one - xs : xs;
               v = 8 * square_q(y, y) - one;
            end
            default: begin
               if (xs > half) v = 8 * square_q(one - xs, xs) - one;
               else v = 8 * square_q(xs, xs) - one;
            end
         endcase
         return settle_sample(v);
      endfunction

      function void note_request(logic [PHASE_BITS-1:0] x, opcode_type op);
         expected_samples.push_back(predict_sample(x, op));
         noted++;
      endfunction

      function void check_sample(logic signed [SAMPLE_BITS-1:0] actual);
         logic signed [SAMPLE_BITS-1:0] want;
         if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: sample %0d arrived with nothing outstanding", actual);
            return;
         end
         want = expected_samples.pop_front();
         checked++;
         if (want !== actual) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("ERROR: sample %0d: expected %0d, got %0d", checked, want, actual);
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [PHASE_BITS-1:0]         req_phase;
   logic [OPCODE_BITS-1:0]        req_opcode;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [SAMPLE_BITS-1:0] rsp_sample;

   shaper_scoreboard board = new();
   int gap_pct;
   int stall_pct;
   int cycle_count;

   oscillator_waveform_shaper i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_phase  (req_phase),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_sample (rsp_sample)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && !req_stall) board.note_request(req_phase, opcode_type'(req_opcode));
         if (rsp_valid && !rsp_stall) board.check_sample(rsp_sample);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("ERROR: timeout after %0d cycles, %0d samples outstanding",
               cycle_count, board.expected_samples.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Stall the result side in random bursts.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Present one transaction at a falling edge and hold it until accepted.
   task automatic send_request(input logic [PHASE_BITS-1:0] ph, input opcode_type op);
      int gap;
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_phase <= ph;
      req_opcode <= op;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic int pick_pct();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 10;
         default: return 35;
      endcase
   endfunction

   initial begin
      int i;
      logic [PHASE_BITS-1:0] ph;
      reset = 1'b1;
      req_valid = 1'b0;
      req_phase = '0;
      req_opcode = '0;
      gap_pct = 0;
      stall_pct = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Quadrant edges and the table end point for sine.
      send_request('0, OP_SINE);
      send_request(QTR_Q, OP_SINE);
      send_request(HALF_Q, OP_SINE);
      send_request(THREE_QTR_Q, OP_SINE);
      send_request('1, OP_SINE);
      // Saturation at +1.0 and the half-cycle switch.
      send_request('0, OP_SQUARE);
      send_request(PHASE_BITS'(HALF_Q - 1), OP_SQUARE);
      send_request(HALF_Q, OP_SQUARE);
      send_request(QTR_Q, OP_TRIANGLE);
      send_request(THREE_QTR_Q, OP_TRIANGLE);
      send_request('0, OP_SAW);
      send_request('1, OP_SAW);
      send_request(PHASE_BITS'(HALF_Q - 1), OP_MOOGSAW);
      send_request(HALF_Q, OP_MOOGSAW);
      // Exactly one half belongs to the rising branch of the quadratic shapes.
      send_request(HALF_Q, OP_MOOG);
      send_request(PHASE_BITS'(HALF_Q + 1), OP_MOOG);
      send_request('1, OP_MOOG);
      send_request(HALF_Q, OP_EXP);
      send_request('0, OP_EXP);
      send_request(HALF_Q, OP_EXP2);
      send_request(PHASE_BITS'(HALF_Q + 1), OP_EXP2);
      send_request(PHASE_BITS'(24'h555555), OP_EXP2);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % BLOCK_ITEMS == 0) begin
            if (RANDOM_ITEMS - i <= QUIET_ITEMS) begin
               gap_pct = 0;
               stall_pct = 0;
            end else begin
               gap_pct = pick_pct();
               stall_pct = pick_pct();
            end
         end
         // Land near a quarter boundary a quarter of the time, wrapping freely.
         if ($urandom_range(0, 3) == 0)
            ph = PHASE_BITS'(($urandom_range(0, 4) << (PHASE_BITS - 2))
                             + $urandom_range(0, 6) - 3);
         else
            ph = PHASE_BITS'($urandom);
         send_request(ph, opcode_type'($urandom_range(0, 7)));
      end
      req_valid <= 1'b0;

      while (board.expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d phase/shape transactions over all eight shapes, boundaries first;",
               board.noted);
      $display("compared %0d samples under idle and stall bursts, %0d mismatches.",
               board.checked, board.mismatches);
      if (board.mismatches == 0 && board.expected_samples.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
